// ===== rtl/pnm_pixel_scale_yuv_to_rgb_core_assert.svh =====
// assertion macros used by the pixel scaler core
`ifndef PNM_PIXEL_SCALE_YUV_TO_RGB_CORE_ASSERT_SVH
`define PNM_PIXEL_SCALE_YUV_TO_RGB_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PNMSC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PNMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pnmsc_pkg.sv =====
package pnmsc_pkg;

    // port widths fixed by the interface
    localparam int FIELD_W = 16;
    localparam int MAX_W   = 16;
    localparam int BYTE_W  = 8;

    // sample bits used and coefficient fraction bits
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 12;

    // scaled value sample*255 and its quotient
    localparam int QW         = SAMPLE_BITS + BYTE_W;
    localparam int STEP_BITS  = 2;
    localparam int DIV_STAGES = (QW + STEP_BITS - 1) / STEP_BITS;
    localparam int QP         = DIV_STAGES * STEP_BITS;

    // color conversion widths
    localparam int CW = QW + 1;
    localparam int KW = COEF_FRAC_BITS + 2;
    localparam int PW = CW + KW;
    localparam int SW = PW + 2;

    localparam int CHROMA_OFFSET = 128;
    localparam int BYTE_MAX      = 255;

    // Q-format coefficients, rounded half up from thousandths
    localparam logic signed [KW-1:0] COEF_R_CR =
        KW'(((1402 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] COEF_G_CR =
        KW'(((714 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] COEF_G_CB =
        KW'(((344 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] COEF_B_CB =
        KW'(((1772 << COEF_FRAC_BITS) + 500) / 1000);

    // accept to output: input stage, divider stages, two merge stages
    localparam int PIPE_DEPTH = DIV_STAGES + 3;

    // output queue
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = FIFO_AW + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YUV_ENABLE = 2'd2;

    localparam logic [MAX_W-1:0] MAX_VALUE_RESET = MAX_W'(BYTE_MAX);

    typedef struct packed {
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [OCC_W-1:0] count;
    } fifo_stat_t;

endpackage

// ===== rtl/pnmsc_div_lane.sv =====
module pnmsc_div_lane (
    input  logic                             clk,
    input  logic [pnmsc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [pnmsc_pkg::MAX_W-1:0]       divisor,
    output logic [pnmsc_pkg::QW-1:0]          quotient
);
    import pnmsc_pkg::*;

    logic [QP-1:0]    dvd_reg  [DIV_STAGES];
    logic [QP-1:0]    dvd_next [DIV_STAGES];
    logic [MAX_W-1:0] rem_reg  [DIV_STAGES];
    logic [MAX_W-1:0] rem_next [DIV_STAGES];
    logic [QP-1:0]    quo_reg  [DIV_STAGES];
    logic [QP-1:0]    quo_next [DIV_STAGES];

    // dividend sample*255 as (sample << 8) - sample
    assign dvd_next[0] = QP'({sample, {BYTE_W{1'b0}}}) - QP'(sample);

    // restoring division, two quotient bits per stage
    genvar gs;
    generate
        for (gs = 0; gs < DIV_STAGES; gs++)
        begin : g_stage
            logic [MAX_W-1:0] rem_in;
            logic [QP-1:0]    quo_in;
            logic [MAX_W-1:0] rem_out;
            logic [QP-1:0]    quo_out;

            if (gs == 0)
            begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[gs-1];
                assign quo_in = quo_reg[gs-1];
            end

            always_comb
            begin : step_comb
                logic [MAX_W:0]   trial;
                logic [MAX_W-1:0] rem_v;
                logic [QP-1:0]    dvd_v;
                logic [QP-1:0]    quo_v;
                rem_v = rem_in;
                dvd_v = dvd_reg[gs];
                quo_v = quo_in;
                for (int b = 0; b < STEP_BITS; b++)
                begin
                    trial = {rem_v, dvd_v[QP-1]};
                    dvd_v = {dvd_v[QP-2:0], 1'b0};
                    if (trial >= {1'b0, divisor})
                    begin
                        rem_v = MAX_W'(trial - {1'b0, divisor});
                        quo_v = {quo_v[QP-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_v = trial[MAX_W-1:0];
                        quo_v = {quo_v[QP-2:0], 1'b0};
                    end
                end
                rem_out = rem_v;
                quo_out = quo_v;
            end

            assign rem_next[gs] = rem_out;
            assign quo_next[gs] = quo_out;

            // dividend moves on by the bits this stage used
            if (gs < DIV_STAGES - 1)
            begin : g_shift
                assign dvd_next[gs+1] = {dvd_reg[gs][QP-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
            end
        end
    endgenerate

    // stage registers, payload only
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            dvd_reg[s] <= dvd_next[s];
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1][QW-1:0];

endmodule

// ===== rtl/pnmsc_merge.sv =====
module pnmsc_merge (
    input  logic                    clk,
    input  logic [pnmsc_pkg::QW-1:0] q_a,
    input  logic [pnmsc_pkg::QW-1:0] q_b,
    input  logic [pnmsc_pkg::QW-1:0] q_c,
    input  logic                    yuv_enable,
    output pnmsc_pkg::pixel_t       pixel
);
    import pnmsc_pkg::*;

    // saturate an unsigned quotient to a byte
    function automatic logic [BYTE_W-1:0] sat_byte(input logic [QW-1:0] q);
        logic [BYTE_W-1:0] res;
        if (q > QW'(BYTE_MAX))
            res = BYTE_W'(BYTE_MAX);
        else
            res = q[BYTE_W-1:0];
        return res;
    endfunction

    // fixed-point sum to byte: negative gives zero, large gives 255
    function automatic logic [BYTE_W-1:0] fix_to_byte(input logic signed [SW-1:0] t);
        logic [BYTE_W-1:0] res;
        if (t[SW-1])
            res = '0;
        else if (|t[SW-2:COEF_FRAC_BITS+BYTE_W])
            res = BYTE_W'(BYTE_MAX);
        else
            res = t[COEF_FRAC_BITS+BYTE_W-1:COEF_FRAC_BITS];
        return res;
    endfunction

    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] cb;

    logic [QW-1:0]        y_reg;
    logic signed [PW-1:0] p_r_reg,  p_r_next;
    logic signed [PW-1:0] p_gr_reg, p_gr_next;
    logic signed [PW-1:0] p_gb_reg, p_gb_next;
    logic signed [PW-1:0] p_b_reg,  p_b_next;
    pixel_t               pass_reg, pass_next;
    logic                 yuv_reg;

    logic signed [SW-1:0] yq;
    logic signed [SW-1:0] t_r;
    logic signed [SW-1:0] t_g;
    logic signed [SW-1:0] t_b;
    pixel_t               pixel_reg, pixel_next;

    // stage one: center chroma, multiply and saturate the pass-through bytes
    always_comb
    begin
        cr = $signed({1'b0, q_b}) - $signed(CW'(CHROMA_OFFSET));
        cb = $signed({1'b0, q_c}) - $signed(CW'(CHROMA_OFFSET));
        p_r_next  = PW'(cr) * PW'(COEF_R_CR);
        p_gr_next = PW'(cr) * PW'(COEF_G_CR);
        p_gb_next = PW'(cb) * PW'(COEF_G_CB);
        p_b_next  = PW'(cb) * PW'(COEF_B_CB);
        pass_next.red   = sat_byte(q_a);
        pass_next.green = sat_byte(q_b);
        pass_next.blue  = sat_byte(q_c);
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= q_a;
        p_r_reg  <= p_r_next;
        p_gr_reg <= p_gr_next;
        p_gb_reg <= p_gb_next;
        p_b_reg  <= p_b_next;
        pass_reg <= pass_next;
        yuv_reg  <= yuv_enable;
    end

    // stage two: sum, clamp and select
    always_comb
    begin
        yq  = SW'($signed({1'b0, y_reg})) <<< COEF_FRAC_BITS;
        t_r = yq + SW'(p_r_reg);
        t_g = yq - SW'(p_gr_reg) - SW'(p_gb_reg);
        t_b = yq + SW'(p_b_reg);
        if (yuv_reg)
        begin
            pixel_next.red   = fix_to_byte(t_r);
            pixel_next.green = fix_to_byte(t_g);
            pixel_next.blue  = fix_to_byte(t_b);
        end
        else
        begin
            pixel_next = pass_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

// ===== rtl/pnmsc_out_fifo.sv =====
module pnmsc_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pnmsc_pkg::pixel_t     wdata,
    input  logic                  pop,
    output pnmsc_pkg::pixel_t     rdata,
    output pnmsc_pkg::fifo_stat_t stat
);
    import pnmsc_pkg::*;

    pixel_t             mem_reg [FIFO_DEPTH];
    pixel_t             rdata_reg;
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]   count_reg,  count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // head read at the next read address, a write to that slot passes through
    always_ff @(posedge clk)
    begin
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[rd_ptr_next];
        end
    end

    assign rdata      = rdata_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == OCC_W'(FIFO_DEPTH));
    assign stat.count = count_reg;

endmodule

// ===== rtl/pnm_pixel_scale_yuv_to_rgb_core.sv =====
// Pixel scaler with optional full-range YCbCr to RGB conversion.
// Input channel: in_valid / in_ready with sample_a, sample_b, sample_c, one
// pixel per item. Output channel: out_valid / out_ready with blue_out,
// green_out, red_out, one result per item, in input order.
// Configuration: cfg_write with cfg_index and cfg_data writes max_value,
// color_mode or yuv_enable at once; write only while no item is in flight.
// Each sample is scaled as sample*255/max_value by three pipelined divider
// lanes, 2 quotient bits per stage over 12 stages; the merge block then does
// the color conversion multiply and the sum with clamping, or a saturated pass-through.
// Throughput: one item per cycle while in_ready is high, set by the fully pipelined divider lanes.
// The pipeline never stalls; results land in a 32-entry output queue and
// in_ready drops only when 32 items are accepted but not yet delivered.
// A stalled receiver fills the queue, then holds off the input side.
// Reset clears the pipeline, the queue and the occupancy count, and loads
// max_value 255, color_mode 1 and yuv_enable 0.
`include "pnm_pixel_scale_yuv_to_rgb_core_assert.svh"

module pnm_pixel_scale_yuv_to_rgb_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pnmsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pnmsc_pkg::MAX_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pnmsc_pkg::FIELD_W-1:0]       sample_a,
    input  logic [pnmsc_pkg::FIELD_W-1:0]       sample_b,
    input  logic [pnmsc_pkg::FIELD_W-1:0]       sample_c,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pnmsc_pkg::BYTE_W-1:0]        blue_out,
    output logic [pnmsc_pkg::BYTE_W-1:0]        green_out,
    output logic [pnmsc_pkg::BYTE_W-1:0]        red_out
);
    import pnmsc_pkg::*;

    logic [MAX_W-1:0]      divisor_reg;
    logic                  color_mode_reg;
    logic                  yuv_enable_reg;
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic                  in_acc;
    logic                  out_acc;
    logic                  push;
    logic [SAMPLE_BITS-1:0] lane_b_sample;
    logic [SAMPLE_BITS-1:0] lane_c_sample;
    logic [QW-1:0]         q_a;
    logic [QW-1:0]         q_b;
    logic [QW-1:0]         q_c;
    pixel_t                merged;
    pixel_t                head;
    fifo_stat_t            fifo_stat;

    // configuration registers, zero max_value divides by one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg    <= MAX_VALUE_RESET;
            color_mode_reg <= 1'b1;
            yuv_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_VALUE:
                begin
                    divisor_reg <= (cfg_data == '0) ? MAX_W'(1) : cfg_data;
                end
                REG_COLOR_MODE:
                begin
                    color_mode_reg <= cfg_data[0];
                end
                REG_YUV_ENABLE:
                begin
                    yuv_enable_reg <= cfg_data[0];
                end
                default:
                begin
                    color_mode_reg <= color_mode_reg;
                end
            endcase
        end
    end

    // handshakes and occupancy credit
    assign in_ready  = (occ_reg != OCC_W'(FIFO_DEPTH));
    assign in_acc    = in_valid && in_ready;
    assign out_valid = !fifo_stat.empty;
    assign out_acc   = out_valid && out_ready;
    assign push      = valid_reg[PIPE_DEPTH-1];

    always_comb
    begin
        valid_next = {valid_reg[PIPE_DEPTH-2:0], in_acc};
        occ_next   = occ_reg + OCC_W'(in_acc) - OCC_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    // gray mode feeds the first sample to every lane
    assign lane_b_sample = color_mode_reg ? sample_b[SAMPLE_BITS-1:0]
                                          : sample_a[SAMPLE_BITS-1:0];
    assign lane_c_sample = color_mode_reg ? sample_c[SAMPLE_BITS-1:0]
                                          : sample_a[SAMPLE_BITS-1:0];

    // scaling lanes
    pnmsc_div_lane u_lane_a (
        .clk      (clk),
        .sample   (sample_a[SAMPLE_BITS-1:0]),
        .divisor  (divisor_reg),
        .quotient (q_a)
    );

    pnmsc_div_lane u_lane_b (
        .clk      (clk),
        .sample   (lane_b_sample),
        .divisor  (divisor_reg),
        .quotient (q_b)
    );

    pnmsc_div_lane u_lane_c (
        .clk      (clk),
        .sample   (lane_c_sample),
        .divisor  (divisor_reg),
        .quotient (q_c)
    );

    // color conversion and clamping
    pnmsc_merge u_merge (
        .clk        (clk),
        .q_a        (q_a),
        .q_b        (q_b),
        .q_c        (q_c),
        .yuv_enable (yuv_enable_reg),
        .pixel      (merged)
    );

    // result queue
    pnmsc_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (merged),
        .pop   (out_acc),
        .rdata (head),
        .stat  (fifo_stat)
    );

    assign blue_out  = head.blue;
    assign green_out = head.green;
    assign red_out   = head.red;

    // checks
    `PNMSC_ASSERT(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(FIFO_DEPTH), "occupancy above queue depth")
    `PNMSC_ASSERT(a_push_room, clk, rst_n, push, !fifo_stat.full, "result pushed into full queue")
    `PNMSC_ASSERT(a_occ_track, clk, rst_n, 1'b1, 32'(occ_reg) == 32'(fifo_stat.count) + $countones(valid_reg), "occupancy does not match items in flight")
    `PNMSC_ASSERT_NEXT(a_pop_frees, clk, rst_n, !in_ready && out_acc, in_ready, "delivery did not free an input slot")

endmodule
